// File: design/tcgr_pkg.sv
// Shared constants, types and codes of the text console glyph renderer.
package tcgr_pkg;

  localparam int unsigned ScreenWidth  = 640;
  localparam int unsigned ScreenHeight = 480;
  localparam int unsigned GlyphW       = 6;
  localparam int unsigned GlyphH       = 13;
  localparam int unsigned GlyphBytes   = 4096;
  localparam int unsigned LineBytes    = ScreenWidth / 8;
  localparam int unsigned FrameBytes   = LineBytes * ScreenHeight;
  localparam int unsigned TextCols     = ScreenWidth / GlyphW;
  localparam int unsigned TextRows     = ScreenHeight / GlyphH;
  localparam int unsigned BandBytes    = LineBytes * GlyphH;
  localparam int unsigned KeepBytes    = BandBytes * (TextRows - 1);

  localparam int unsigned FrameAw = $clog2(FrameBytes);
  localparam int unsigned GlyphAw = $clog2(GlyphBytes);

  localparam logic [7:0] PixelMask = 8'hFC;
  localparam logic [7:0] Newline   = 8'd10;

  typedef enum logic [2:0] {
    OpPutChar  = 3'd0,
    OpSetPos   = 3'd1,
    OpClear    = 3'd2,
    OpCurShow  = 3'd3,
    OpCurHide  = 3'd4,
    OpLoadGlyph = 3'd5,
    OpReadFrame = 3'd6,
    OpNone     = 3'd7
  } op_e;

  typedef enum logic [3:0] {
    StIdle,
    StCellRd,
    StCellWait,
    StCellWr,
    StScrollRd,
    StScrollWait,
    StScrollWr,
    StFill,
    StRead,
    StReadWait,
    StDone
  } state_e;

endpackage

// File: design/text_console_glyph_renderer.sv
// Top level of the text console glyph renderer: sequencer around the frame and glyph stores.
//
// Usage: an operation is offered on the request channel (req_valid_i/req_stall_o with the
// op_i, char_code_i, column_i, row_i, address_i and data_i fields). One result per request
// comes back on the response channel (rsp_valid_o/rsp_stall_i) carrying read_data_o and
// the cursor state after the operation. The block takes one request at a time and holds
// req_stall_o high until the result of the current request has been taken.
// States per operation, all through the frame store, one byte access at a time:
//   set position, cursor none-change, glyph load, op 7: straight to StDone.
//   frame read: StRead, StReadWait, then StDone.
//   put char, cursor show/hide: per byte of 13 lines, StCellRd, StCellWait, StCellWr.
//   a wrap past the last row adds a scroll: 36400 kept bytes are copied via StScrollRd,
//   StScrollWait and StScrollWr, then 2000 cleared bytes are zeroed in StFill.
//   clear: StFill zeroes every frame byte (38400 bytes).
// After reset the frame store is swept to zero (38400 bytes) before the first request is
// taken. A stalled response holds its value and the block waits for it.
module text_console_glyph_renderer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  output logic        req_stall_o,
  input  logic [2:0]  op_i,
  input  logic [7:0]  char_code_i,
  input  logic [6:0]  column_i,
  input  logic [5:0]  row_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  data_i,
  output logic        rsp_valid_o,
  input  logic        rsp_stall_i,
  output logic [7:0]  read_data_o,
  output logic [6:0]  cursor_column_o,
  output logic [5:0]  cursor_row_o,
  output logic        cursor_shown_o
);
  import tcgr_pkg::*;

  // Stores.
  logic [7:0] frame_mem [FrameBytes];
  logic [7:0] glyph_mem [GlyphBytes];

  state_e state_q, state_d;
  logic [6:0]  col_q, col_d;
  logic [5:0]  row_q, row_d;
  logic        shown_q, shown_d;
  logic [7:0]  rd_q, rd_d;
  logic        rsp_valid_q, rsp_valid_d;
  logic        flip_q, flip_d;
  logic        sweep_q, sweep_d;
  logic [7:0]  code_q, code_d;
  logic [15:0] addr_q, addr_d;
  logic [3:0]  line_q, line_d;
  logic        half_q, half_d;
  logic [FrameAw-1:0] fa_q, fa_d;
  logic [FrameAw-1:0] base_q, base_d;
  logic [2:0]  sh_q, sh_d;
  logic [6:0]  byte_q, byte_d;

  // Frame port controls.
  logic               f_we;
  logic [FrameAw-1:0] f_waddr;
  logic [7:0]         f_wdata;
  logic [FrameAw-1:0] f_raddr;
  logic [7:0]         f_rdata_q;
  logic [7:0]         g_rdata_q;
  logic               g_we;
  logic [GlyphAw-1:0] g_raddr;

  always_ff @(posedge clk_i) begin
    if (f_we) begin
      frame_mem[f_waddr] <= f_wdata;
    end
    f_rdata_q <= frame_mem[f_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (g_we) begin
      glyph_mem[address_i[GlyphAw-1:0]] <= data_i;
    end
    g_rdata_q <= glyph_mem[g_raddr];
  end

  // Merge data for the byte being touched.
  logic [7:0] g_bits, bits, keepm;
  logic [2:0] s2;
  logic [7:0] merged;
  logic       accept;
  logic [6:0] col_inc;
  logic [9:0] bitpos;

  always_comb begin
    g_bits = flip_q ? PixelMask : (g_rdata_q & PixelMask);
    s2     = 3'(4'd8 - {1'b0, sh_q});
    if (!half_q) begin
      bits  = g_bits >> sh_q;
      keepm = ~(PixelMask >> sh_q);
    end else begin
      bits  = g_bits << s2;
      keepm = ~(PixelMask << s2);
    end
    merged = flip_q ? (f_rdata_q ^ bits) : ((f_rdata_q & keepm) | bits);
  end

  // Requests are taken only when idle and no response is held back.
  assign req_stall_o = (state_q != StIdle) || (rsp_valid_q && rsp_stall_i);
  assign accept  = req_valid_i && !req_stall_o;
  assign col_inc = col_q + 7'd1;
  assign bitpos  = 10'(col_q) * 10'(GlyphW);

  always_comb begin
    state_d     = state_q;
    col_d       = col_q;
    row_d       = row_q;
    shown_d     = shown_q;
    rd_d        = rd_q;
    rsp_valid_d = rsp_valid_q;
    flip_d      = flip_q;
    sweep_d     = sweep_q;
    code_d      = code_q;
    addr_d      = addr_q;
    line_d      = line_q;
    half_d      = half_q;
    fa_d        = fa_q;
    base_d      = base_q;
    sh_d        = sh_q;
    byte_d      = byte_q;
    f_we        = 1'b0;
    f_waddr     = fa_q;
    f_wdata     = 8'd0;
    f_raddr     = fa_q;
    g_we        = 1'b0;
    g_raddr     = GlyphAw'({code_q, line_q});

    if (rsp_valid_q && !rsp_stall_i) begin
      rsp_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          rd_d   = 8'd0;
          code_d = char_code_i;
          addr_d = address_i;
          line_d = 4'd0;
          half_d = 1'b0;
          sh_d   = bitpos[2:0];
          byte_d = bitpos[9:3];
          base_d = FrameAw'(32'(row_q) * BandBytes + 32'(bitpos[9:3]));
          state_d = StDone;
          case (op_e'(op_i))
            OpPutChar: begin
              flip_d = 1'b0;
              if (char_code_i == Newline) begin
                col_d  = 7'd0;
                state_d = StDone;
                if (32'(row_q) + 1 >= TextRows) begin
                  fa_d    = '0;
                  state_d = StScrollRd;
                end else begin
                  row_d = row_q + 6'd1;
                end
              end else begin
                state_d = StCellRd;
              end
            end
            OpSetPos: begin
              col_d = (32'(column_i) < TextCols) ? column_i : 7'(TextCols - 1);
              row_d = (32'(row_i) < TextRows) ? row_i : 6'(TextRows - 1);
            end
            OpClear: begin
              col_d   = 7'd0;
              row_d   = 6'd0;
              shown_d = 1'b0;
              fa_d    = '0;
              state_d = StFill;
            end
            OpCurShow: begin
              flip_d = 1'b1;
              if (!shown_q) state_d = StCellRd;
            end
            OpCurHide: begin
              flip_d = 1'b1;
              if (shown_q) state_d = StCellRd;
            end
            OpLoadGlyph: begin
              g_we = (32'(address_i) < GlyphBytes);
            end
            OpReadFrame: begin
              if (32'(address_i) < FrameBytes) state_d = StRead;
            end
            default: ;
          endcase
        end
      end

      // Read one frame byte of the cell; glyph byte is read alongside.
      StCellRd: begin
        fa_d = base_q + FrameAw'(half_q);
        f_raddr = base_q + FrameAw'(half_q);
        state_d = StCellWait;
        if (32'(byte_q) + 32'(half_q) >= LineBytes ||
            32'(row_q) * GlyphH + 32'(line_q) >= ScreenHeight) begin
          state_d = StCellWr;
        end
      end
      StCellWait: begin
        state_d = StCellWr;
      end
      StCellWr: begin
        if (32'(byte_q) + 32'(half_q) < LineBytes &&
            32'(row_q) * GlyphH + 32'(line_q) < ScreenHeight) begin
          f_we = 1'b1;
          f_wdata = merged;
        end
        if (!half_q && sh_q > 3'd2) begin
          half_d  = 1'b1;
          state_d = StCellRd;
        end else begin
          half_d = 1'b0;
          if (32'(line_q) == GlyphH - 1) begin
            if (flip_q) begin
              shown_d = !shown_q;
              state_d = StDone;
            end else if (32'(col_inc) >= TextCols) begin
              col_d = 7'd0;
              if (32'(row_q) + 1 >= TextRows) begin
                fa_d    = '0;
                state_d = StScrollRd;
              end else begin
                row_d   = row_q + 6'd1;
                state_d = StDone;
              end
            end else begin
              col_d   = col_inc;
              state_d = StDone;
            end
          end else begin
            line_d  = line_q + 4'd1;
            base_d  = base_q + FrameAw'(LineBytes);
            state_d = StCellRd;
          end
        end
      end

      // Scroll: copy each kept byte up from one text row below.
      StScrollRd: begin
        f_raddr = fa_q + FrameAw'(BandBytes);
        state_d = StScrollWait;
      end
      StScrollWait: begin
        f_raddr = fa_q + FrameAw'(BandBytes);
        state_d = StScrollWr;
      end
      StScrollWr: begin
        f_we    = 1'b1;
        f_wdata = f_rdata_q;
        fa_d    = fa_q + FrameAw'(1);
        state_d = (32'(fa_q) == KeepBytes - 1) ? StFill : StScrollRd;
      end

      // Zero fill from fa_q to the end of the store; the sweep after reset gives no response.
      StFill: begin
        f_we    = 1'b1;
        f_wdata = 8'd0;
        fa_d    = fa_q + FrameAw'(1);
        if (32'(fa_q) == FrameBytes - 1) begin
          state_d = sweep_q ? StIdle : StDone;
          sweep_d = 1'b0;
        end
      end

      StRead: begin
        f_raddr = FrameAw'(addr_q);
        state_d = StReadWait;
      end
      StReadWait: begin
        rd_d = f_rdata_q;
        state_d = StDone;
      end

      StDone: begin
        rsp_valid_d = 1'b1;
        state_d     = StIdle;
        if (rsp_valid_q && rsp_stall_i) state_d = StDone;
        if (rsp_valid_q && rsp_stall_i) rsp_valid_d = 1'b1;
      end

      default: state_d = StIdle;
    endcase
  end

  // Reset leaves the sequencer sweeping the frame store to zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StFill;
      col_q       <= '0;
      row_q       <= '0;
      shown_q     <= 1'b0;
      rsp_valid_q <= 1'b0;
      fa_q        <= '0;
      rd_q        <= '0;
      sweep_q     <= 1'b1;
    end else begin
      state_q     <= state_d;
      col_q       <= col_d;
      row_q       <= row_d;
      shown_q     <= shown_d;
      rsp_valid_q <= rsp_valid_d;
      fa_q        <= fa_d;
      rd_q        <= rd_d;
      sweep_q     <= sweep_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flip_q <= 1'b0;
      code_q <= 8'hFF;
    end else begin
      flip_q <= flip_d;
      code_q <= code_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    line_q <= line_d;
    half_q <= half_d;
    base_q <= base_d;
    sh_q   <= sh_d;
    byte_q <= byte_d;
  end

  assign rsp_valid_o     = rsp_valid_q;
  assign read_data_o     = rd_q;
  assign cursor_column_o = col_q;
  assign cursor_row_o    = row_q;
  assign cursor_shown_o  = shown_q;

endmodule

// File: design/tcgr_checker.sv
// Port-level checks of the text console glyph renderer, bound to the top level.
module tcgr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       req_valid_i,
  input logic       req_stall_o,
  input logic       rsp_valid_o,
  input logic       rsp_stall_i,
  input logic [7:0] read_data_o,
  input logic [6:0] cursor_column_o,
  input logic [5:0] cursor_row_o
);
  import tcgr_pkg::*;

  // A stalled response keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_stall_i |=> rsp_valid_o && $stable(read_data_o))
    else $error("response changed while stalled");

  // No new request is taken while a response is held back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_stall_i |-> req_stall_o)
    else $error("request taken with response pending");

  // The cursor stays inside the text grid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cursor_column_o) < TextCols && 32'(cursor_row_o) < TextRows)
    else $error("cursor out of range");

  // An accepted request is not answered in the very next cycle's edge.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && !req_stall_o |=> !rsp_valid_o)
    else $error("response too early");

endmodule

bind text_console_glyph_renderer tcgr_checker u_tcgr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .req_valid_i    (req_valid_i),
  .req_stall_o    (req_stall_o),
  .rsp_valid_o    (rsp_valid_o),
  .rsp_stall_i    (rsp_stall_i),
  .read_data_o    (read_data_o),
  .cursor_column_o(cursor_column_o),
  .cursor_row_o   (cursor_row_o)
);
